### hw/rtl/mono_glyph_extent_accumulator_top_macros.svh
// Assertion macros shared by the RTL.
`ifndef MONO_GLYPH_EXTENT_ACCUMULATOR_TOP_MACROS_SVH
`define MONO_GLYPH_EXTENT_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define MGEA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MGEA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mgea_pkg.sv
package mgea_pkg;

  localparam int COORD_BITS_DEF      = 32;
  localparam int SCALE_FRAC_BITS_DEF = 12;
  localparam int COORD_MAX_BITS      = 64;

  localparam int FIELD_BITS    = 32;
  localparam int CFG_BITS      = 31;
  localparam int WIDTH_BITS    = 33;
  localparam int DIFF_BITS     = 34;
  localparam int OFFSET_BITS   = 33;
  localparam int QUOT_BITS     = 4;
  localparam int DIGIT_BITS    = 4;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_ADVANCE_WIDTH = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_WIDTH     = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_LINE_TOP      = 2'd2;

  typedef struct packed {
    logic                         start_of_string;
    logic signed [FIELD_BITS-1:0] glyph_logical_left;
    logic signed [FIELD_BITS-1:0] glyph_logical_right;
    logic signed [FIELD_BITS-1:0] glyph_ink_left;
    logic signed [FIELD_BITS-1:0] glyph_ink_right;
    logic signed [FIELD_BITS-1:0] glyph_logical_bottom;
    logic signed [FIELD_BITS-1:0] glyph_logical_top;
    logic signed [FIELD_BITS-1:0] glyph_ink_bottom;
    logic signed [FIELD_BITS-1:0] glyph_ink_top;
  } glyph_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] text_logical_left;
    logic signed [FIELD_BITS-1:0] text_logical_right;
    logic signed [FIELD_BITS-1:0] text_ink_left;
    logic signed [FIELD_BITS-1:0] text_ink_right;
    logic signed [FIELD_BITS-1:0] text_logical_bottom;
    logic signed [FIELD_BITS-1:0] text_logical_top;
    logic signed [FIELD_BITS-1:0] text_ink_bottom;
    logic signed [FIELD_BITS-1:0] text_ink_top;
  } extent_t;

  typedef struct packed {
    logic load;
    logic step;
    logic trunc;
    logic place;
  } edge_ctrl_t;

  function automatic int mul_digits(int frac_bits);
    return (frac_bits + DIGIT_BITS) / DIGIT_BITS;
  endfunction

  function automatic int fq_bits(int frac_bits);
    return mul_digits(frac_bits) * DIGIT_BITS;
  endfunction

  function automatic int sum_bits(int coord_bits);
    return ((coord_bits > DIFF_BITS) ? coord_bits : DIFF_BITS) + 2;
  endfunction

endpackage

### hw/rtl/mgea_if.sv
interface mgea_glyph_if import mgea_pkg::*; ();
  logic   valid;
  logic   ready;
  glyph_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mgea_extent_if import mgea_pkg::*; ();
  logic    valid;
  logic    ready;
  extent_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/mgea_qdiv.sv
module mgea_qdiv import mgea_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CFG_BITS-1:0]   dividend,
  input  logic [WIDTH_BITS-1:0] divisor,
  output logic [QUOT_BITS-1:0]  quot,
  output logic                  done
);

  localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

  logic [WIDTH_BITS-1:0] rem;
  logic [WIDTH_BITS-1:0] dsr;
  logic [WIDTH_BITS:0]   shifted;
  logic                  fits;
  logic [CNT_BITS-1:0]   cnt;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(QUOT_BITS);
      end else if (cnt != '0) begin
        cnt  <= cnt - CNT_BITS'(1);
        done <= (cnt == CNT_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= WIDTH_BITS'(dividend);
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem  <= fits ? WIDTH_BITS'(shifted - {1'b0, dsr}) : WIDTH_BITS'(shifted);
      quot <= {quot[QUOT_BITS-2:0], fits};
    end
  end

endmodule

### hw/rtl/mgea_edge.sv
module mgea_edge import mgea_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  edge_ctrl_t                                ctrl,
  input  logic signed [FIELD_BITS-1:0]              edge_in,
  input  logic [fq_bits(SCALE_FRAC_BITS)-1:0]       fq,
  input  logic signed [sum_bits(COORD_BITS)-1:0]    base,
  output logic signed [COORD_BITS-1:0]              placed
);

  localparam int FQ_BITS   = fq_bits(SCALE_FRAC_BITS);
  localparam int SUM_BITS  = sum_bits(COORD_BITS);
  localparam int ACC_BITS  = FQ_BITS + FIELD_BITS + 1;
  localparam int PROD_BITS = FIELD_BITS + DIGIT_BITS + 1;

  localparam logic signed [ACC_BITS-1:0] ROUND_UP =
    {{(ACC_BITS - SCALE_FRAC_BITS){1'b0}}, {SCALE_FRAC_BITS{1'b1}}};
  localparam logic signed [SUM_BITS-1:0] POS_HI =
    {{(SUM_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] POS_LO = ~POS_HI;

  logic [FQ_BITS-1:0]          digits;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  acc_next;
  logic signed [PROD_BITS-1:0] part;
  logic signed [ACC_BITS-1:0]  rounded;
  logic signed [FIELD_BITS-1:0] scaled;
  logic signed [SUM_BITS-1:0]  pos;
  logic signed [COORD_BITS-1:0] placed_next;

  assign part = PROD_BITS'(edge_in)
              * PROD_BITS'($signed({1'b0, digits[FQ_BITS-1 -: DIGIT_BITS]}));
  assign acc_next = (acc <<< DIGIT_BITS) + ACC_BITS'(part);

  // truncate toward zero
  assign rounded = acc[ACC_BITS-1] ? acc + ROUND_UP : acc;

  assign pos = base + SUM_BITS'(scaled);

  always_comb begin
    if (pos > POS_HI) begin
      placed_next = COORD_BITS'(POS_HI);
    end else if (pos < POS_LO) begin
      placed_next = COORD_BITS'(POS_LO);
    end else begin
      placed_next = COORD_BITS'(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digits <= fq;
      acc    <= '0;
    end else if (ctrl.step) begin
      digits <= digits << DIGIT_BITS;
      acc    <= acc_next;
    end
    if (ctrl.trunc) begin
      scaled <= FIELD_BITS'(rounded >>> SCALE_FRAC_BITS);
    end
    if (ctrl.place) begin
      placed <= placed_next;
    end
  end

endmodule

### hw/rtl/mono_glyph_extent_accumulator_top.sv
// Channel  | Dir | Beat                     | Accepted when
// glyph    | in  | start flag + 8 glyph edges | glyph.valid && glyph.ready
// extent   | out | 8 union box edges        | extent.valid && extent.ready
// apb      | cfg | 3 registers at 0, 4, 8   | psel && penable && pwrite
//
// Each glyph passes the width, check, multiply, truncate, place and done steps, with a divide
// step when squeezed; the edge multipliers use 4-bit digits and the divider is 4-bit restoring.
// Reset clears registers, pen and union box at once; no clearing pass.
// One box waits in the output register while the next glyph is taken.
// A second box waits in the final step until the first beat is taken.
`include "mono_glyph_extent_accumulator_top_macros.svh"

module mono_glyph_extent_accumulator_top import mgea_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  mgea_glyph_if.sink               glyph,
  mgea_extent_if.source            extent
);

  localparam int FQ_BITS      = fq_bits(SCALE_FRAC_BITS);
  localparam int MUL_DIGITS   = mul_digits(SCALE_FRAC_BITS);
  localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS);
  localparam int SUM_BITS     = sum_bits(COORD_BITS);
  localparam int UNION_BITS   = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int PEN_BITS     = COORD_BITS - 1;
  localparam int PEN_SUM_BITS = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;

  localparam logic [FQ_BITS-1:0] FQ_UNITY = FQ_BITS'(1) << SCALE_FRAC_BITS;
  localparam logic [FQ_BITS-1:0] FQ_FLOOR =
    FQ_BITS'(((1 << SCALE_FRAC_BITS) + 50) / 100);
  localparam logic [MUL_CNT_BITS-1:0] MUL_LAST = MUL_CNT_BITS'(MUL_DIGITS - 1);
  localparam logic [PEN_SUM_BITS-1:0] PEN_MAX =
    {{(PEN_SUM_BITS - PEN_BITS){1'b0}}, {PEN_BITS{1'b1}}};

  localparam int UNION_LOGICAL_TOP = 5;
  localparam int UNION_INK_TOP     = 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WIDTH = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_TRUNC = 3'd5;
  localparam logic [2:0] S_PLACE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [CFG_BITS-1:0]          advance_width;
  logic [CFG_BITS-1:0]          max_width;
  logic signed [FIELD_BITS-1:0] line_top;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  glyph_t                        item;
  logic signed [WIDTH_BITS-1:0]  width;
  logic signed [WIDTH_BITS-1:0]  width_next;
  logic signed [WIDTH_BITS-1:0]  subtrahend;
  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [OFFSET_BITS-1:0] offset;
  logic                          big;
  logic signed [SUM_BITS-1:0]    pen_offset;
  logic signed [SUM_BITS-1:0]    base;
  logic signed [SUM_BITS-1:0]    base_next;
  logic [PEN_BITS-1:0]           pen;
  logic [PEN_SUM_BITS-1:0]       pen_sum;
  logic [PEN_BITS-1:0]           pen_next;
  logic [MUL_CNT_BITS-1:0]       mul_cnt;
  logic                          accept;
  logic                          go;
  logic                          cfg_write;
  logic [REG_IDX_BITS-1:0]       reg_idx;

  logic                          div_done;
  logic [QUOT_BITS-1:0]          quot;
  logic [FQ_BITS-1:0]            fq;
  edge_ctrl_t                    lane_ctrl;

  logic signed [FIELD_BITS-1:0]  edge_in [4];
  logic signed [FIELD_BITS-1:0]  vert [4];
  logic signed [COORD_BITS-1:0]  edge_h [4];
  logic signed [UNION_BITS-1:0]  union_box [8];
  logic signed [UNION_BITS-1:0]  union_next [8];
  extent_t                       box_next;

  // configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_ADVANCE_WIDTH: prdata = {1'b0, advance_width};
      REG_MAX_WIDTH:     prdata = {1'b0, max_width};
      REG_LINE_TOP:      prdata = line_top;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      advance_width <= '0;
      max_width     <= '0;
      line_top      <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ADVANCE_WIDTH: advance_width <= pwdata[CFG_BITS-1:0];
        REG_MAX_WIDTH:     max_width     <= pwdata[CFG_BITS-1:0];
        REG_LINE_TOP:      line_top      <= pwdata;
        default:           ;
      endcase
    end
  end

  // control
  assign glyph.ready = (state == S_IDLE);
  assign accept      = glyph.valid && glyph.ready;
  assign go          = !extent.valid || extent.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_WIDTH;
      S_WIDTH: state_next = S_CHECK;
      S_CHECK: state_next = big ? S_DIV : S_MUL;
      S_DIV:   if (div_done) state_next = S_MUL;
      S_MUL:   if (mul_cnt == MUL_LAST) state_next = S_TRUNC;
      S_TRUNC: state_next = S_PLACE;
      S_PLACE: state_next = S_DONE;
      S_DONE:  if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // width, squeeze decision and centring offset
  assign width_next = WIDTH_BITS'($signed(item.glyph_logical_right))
                    - WIDTH_BITS'($signed(item.glyph_logical_left));
  assign big        = width > $signed({2'b00, max_width});
  assign subtrahend = big ? $signed({2'b00, max_width}) : width;
  assign diff       = DIFF_BITS'($signed({1'b0, advance_width})) - DIFF_BITS'(subtrahend);

  // pen plus offset, saturated at the 64-bit upper limit only when COORD_BITS is 64
  assign pen_offset = $signed(SUM_BITS'({1'b0, pen})) + SUM_BITS'(offset);

  if (COORD_BITS == COORD_MAX_BITS) begin : g_sat
    localparam logic signed [SUM_BITS-1:0] TOP64 =
      {{(SUM_BITS - COORD_MAX_BITS + 1){1'b0}}, {(COORD_MAX_BITS - 1){1'b1}}};
    assign base_next = (pen_offset > TOP64) ? TOP64 : pen_offset;
  end else begin : g_nosat
    assign base_next = pen_offset;
  end

  assign pen_sum  = PEN_SUM_BITS'(pen) + PEN_SUM_BITS'(advance_width);
  assign pen_next = (pen_sum > PEN_MAX) ? PEN_BITS'(PEN_MAX) : pen_sum[PEN_BITS-1:0];

  // squeeze factor
  always_comb begin
    if (state == S_DIV) begin
      fq = (quot == '0) ? FQ_FLOOR
                        : FQ_BITS'(quot) << (SCALE_FRAC_BITS - QUOT_BITS);
    end else begin
      fq = FQ_UNITY;
    end
  end

  assign lane_ctrl.load  = ((state == S_CHECK) && !big) || ((state == S_DIV) && div_done);
  assign lane_ctrl.step  = (state == S_MUL);
  assign lane_ctrl.trunc = (state == S_TRUNC);
  assign lane_ctrl.place = (state == S_PLACE);

  mgea_qdiv u_qdiv (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_CHECK) && big),
    .dividend (max_width),
    .divisor  (width),
    .quot     (quot),
    .done     (div_done)
  );

  assign edge_in[0] = item.glyph_logical_left;
  assign edge_in[1] = item.glyph_logical_right;
  assign edge_in[2] = item.glyph_ink_left;
  assign edge_in[3] = item.glyph_ink_right;
  assign vert[0]    = item.glyph_logical_bottom;
  assign vert[1]    = item.glyph_logical_top;
  assign vert[2]    = item.glyph_ink_bottom;
  assign vert[3]    = item.glyph_ink_top;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    mgea_edge #(
      .COORD_BITS      (COORD_BITS),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_edge (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .edge_in (edge_in[k]),
      .fq      (fq),
      .base    (base),
      .placed  (edge_h[k])
    );
  end

  // union: even edges take the minimum, odd edges the maximum
  for (genvar k = 0; k < 8; k++) begin : g_union
    logic signed [UNION_BITS-1:0] cand;
    if (k < 4) begin : g_horiz
      assign cand = UNION_BITS'(edge_h[k]);
    end else begin : g_vert
      assign cand = UNION_BITS'(vert[k-4]);
    end
    if (k % 2 == 0) begin : g_min
      assign union_next[k] = (cand < union_box[k]) ? cand : union_box[k];
    end else begin : g_max
      assign union_next[k] = (cand > union_box[k]) ? cand : union_box[k];
    end
  end

  assign box_next.text_logical_left   = union_next[0][FIELD_BITS-1:0];
  assign box_next.text_logical_right  = union_next[1][FIELD_BITS-1:0];
  assign box_next.text_ink_left       = union_next[2][FIELD_BITS-1:0];
  assign box_next.text_ink_right      = union_next[3][FIELD_BITS-1:0];
  assign box_next.text_logical_bottom = union_next[4][FIELD_BITS-1:0];
  assign box_next.text_logical_top    = union_next[5][FIELD_BITS-1:0];
  assign box_next.text_ink_bottom     = union_next[6][FIELD_BITS-1:0];
  assign box_next.text_ink_top        = union_next[7][FIELD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_cnt <= '0;
      pen     <= '0;
      for (int k = 0; k < 8; k++) begin
        union_box[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (lane_ctrl.load) begin
        mul_cnt <= '0;
      end else if (state == S_MUL) begin
        mul_cnt <= mul_cnt + MUL_CNT_BITS'(1);
      end
      if (accept && glyph.payload.start_of_string) begin
        pen <= '0;
        for (int k = 0; k < 8; k++) begin
          if (k == UNION_LOGICAL_TOP || k == UNION_INK_TOP) begin
            union_box[k] <= UNION_BITS'(line_top);
          end else begin
            union_box[k] <= '0;
          end
        end
      end else if ((state == S_DONE) && go) begin
        pen <= pen_next;
        for (int k = 0; k < 8; k++) begin
          union_box[k] <= union_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= glyph.payload;
    end
    if (state == S_WIDTH) begin
      width <= width_next;
    end
    if (state == S_CHECK) begin
      offset <= OFFSET_BITS'(diff >>> 1);
    end
    if (state == S_TRUNC) begin
      base <= base_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      extent.valid <= 1'b0;
    end else if ((state == S_DONE) && go) begin
      extent.valid <= 1'b1;
    end else if (extent.ready) begin
      extent.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && go) begin
      extent.payload <= box_next;
    end
  end

  `MGEA_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !glyph.ready, "glyph taken while busy")
  `MGEA_ASSERT_IMP(a_div_done_in_div, clk, rst, div_done, state == S_DIV, "stray divide done")
  `MGEA_ASSERT_NXT(a_unscaled_skips_div, clk, rst, (state == S_CHECK) && !big, state == S_MUL, "unscaled glyph entered divide")
  `MGEA_ASSERT_IMP(a_box_from_done, clk, rst, $rose(extent.valid), $past(state) == S_DONE, "box beat without finished glyph")

endmodule

### bench/mono_glyph_extent_accumulator_top_tb.sv
module mono_glyph_extent_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mgea_pkg::*;

  localparam longint COORD_HI   = 64'sh7FFF_FFFF;
  localparam longint COORD_LO   = -COORD_HI - 1;
  localparam int     SCALE_FRAC = SCALE_FRAC_BITS_DEF;
  localparam int     INT_MAX    = 2147483647;
  localparam int     INT_MIN    = -2147483647 - 1;
  localparam int     STALL_LIMIT = 4000;
  localparam int     HOLD_SPAN   = 150;
  localparam int     BATCH       = 66;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  mgea_glyph_if  glyph_bus ();
  mgea_extent_if box_bus ();

  mono_glyph_extent_accumulator_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .glyph   (glyph_bus),
    .extent  (box_bus)
  );

  // layout registers and running state as the block should hold them
  longint cfg_adv;
  longint cfg_max;
  longint cfg_top;
  longint pen_pos;
  longint union_edge [8];

  glyph_t  glyph_q [$];
  extent_t union_box_q [$];

  string box_field [8] = '{"logical_left", "logical_right", "ink_left", "ink_right",
                           "logical_bottom", "logical_top", "ink_bottom", "ink_top"};

  int  faults;
  int  glyphs_sent;
  int  boxes_seen;
  int  strings_started;
  int  layouts;
  int  holds_done;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  int  string_left;
  int  quiet_cycles;
  bit  quiet;
  bit  hold_req;

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] coord32(longint v);
    longint c;
    c = clamp_coord(v);
    return c[FIELD_BITS-1:0];
  endfunction

  function automatic longint rnd(int lo, int hi);
    return longint'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic extent_t place_glyph(glyph_t gi);
    longint  g [8];
    longint  h [4];
    longint  w;
    longint  offset;
    longint  q;
    longint  fq;
    extent_t r;
    g[0] = gi.glyph_logical_left;
    g[1] = gi.glyph_logical_right;
    g[2] = gi.glyph_ink_left;
    g[3] = gi.glyph_ink_right;
    g[4] = gi.glyph_logical_bottom;
    g[5] = gi.glyph_logical_top;
    g[6] = gi.glyph_ink_bottom;
    g[7] = gi.glyph_ink_top;
    if (gi.start_of_string) begin
      strings_started++;
      for (int k = 0; k < 8; k++) union_edge[k] = 0;
      union_edge[5] = cfg_top;
      union_edge[7] = cfg_top;
      pen_pos = 0;
    end
    w = g[1] - g[0];
    if (w <= cfg_max) begin
      offset = (cfg_adv - w) >>> 1;
      for (int k = 0; k < 4; k++) h[k] = clamp_coord(pen_pos + offset + g[k]);
    end else begin
      q = (16 * cfg_max) / w;
      if (q <= 0) fq = ((longint'(1) <<< SCALE_FRAC) + 50) / 100;
      else fq = q <<< (SCALE_FRAC - 4);
      offset = (cfg_adv - cfg_max) >>> 1;
      for (int k = 0; k < 4; k++)
        h[k] = clamp_coord(pen_pos + offset + (fq * g[k]) / (longint'(1) <<< SCALE_FRAC));
    end
    if (h[0] < union_edge[0]) union_edge[0] = h[0];
    if (h[1] > union_edge[1]) union_edge[1] = h[1];
    if (h[2] < union_edge[2]) union_edge[2] = h[2];
    if (h[3] > union_edge[3]) union_edge[3] = h[3];
    if (g[4] < union_edge[4]) union_edge[4] = g[4];
    if (g[5] > union_edge[5]) union_edge[5] = g[5];
    if (g[6] < union_edge[6]) union_edge[6] = g[6];
    if (g[7] > union_edge[7]) union_edge[7] = g[7];
    pen_pos = clamp_coord(pen_pos + cfg_adv);
    r.text_logical_left   = union_edge[0][FIELD_BITS-1:0];
    r.text_logical_right  = union_edge[1][FIELD_BITS-1:0];
    r.text_ink_left       = union_edge[2][FIELD_BITS-1:0];
    r.text_ink_right      = union_edge[3][FIELD_BITS-1:0];
    r.text_logical_bottom = union_edge[4][FIELD_BITS-1:0];
    r.text_logical_top    = union_edge[5][FIELD_BITS-1:0];
    r.text_ink_bottom     = union_edge[6][FIELD_BITS-1:0];
    r.text_ink_top        = union_edge[7][FIELD_BITS-1:0];
    return r;
  endfunction

  function automatic glyph_t glyph_of(bit sos, int ll, int lr, int il, int ir,
                                      int lb, int lt, int ib, int it);
    glyph_t g;
    g.start_of_string      = sos;
    g.glyph_logical_left   = ll;
    g.glyph_logical_right  = lr;
    g.glyph_ink_left       = il;
    g.glyph_ink_right      = ir;
    g.glyph_logical_bottom = lb;
    g.glyph_logical_top    = lt;
    g.glyph_ink_bottom     = ib;
    g.glyph_ink_top        = it;
    return g;
  endfunction

  function automatic glyph_t random_glyph(bit first);
    glyph_t g;
    longint ll;
    longint lr;
    longint w;
    longint lb;
    longint lt;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      g.start_of_string      = 1'($urandom);
      g.glyph_logical_left   = $urandom;
      g.glyph_logical_right  = $urandom;
      g.glyph_ink_left       = $urandom;
      g.glyph_ink_right      = $urandom;
      g.glyph_logical_bottom = $urandom;
      g.glyph_logical_top    = $urandom;
      g.glyph_ink_bottom     = $urandom;
      g.glyph_ink_top        = $urandom;
      return g;
    end
    ll = rnd(-1000, 1000);
    if (pick < 14) w = -rnd(1, 3000);
    else if (pick < 60) w = longint'($urandom_range(0, int'(cfg_max)));
    else w = cfg_max + 1 + (longint'($urandom) % (16 * cfg_max + 16));
    lr = ll + w;
    lb = -rnd(0, 400);
    lt = rnd(0, 1200);
    g.start_of_string      = first;
    g.glyph_logical_left   = coord32(ll);
    g.glyph_logical_right  = coord32(lr);
    g.glyph_ink_left       = coord32(ll + rnd(-30, 30));
    g.glyph_ink_right      = coord32(lr + rnd(-30, 30));
    g.glyph_logical_bottom = coord32(lb);
    g.glyph_logical_top    = coord32(lt);
    g.glyph_ink_bottom     = coord32(lb + rnd(0, 100));
    g.glyph_ink_top        = coord32(lt - rnd(0, 100));
    return g;
  endfunction

  function automatic int idle_span();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ADVANCE_WIDTH: cfg_adv = longint'(data[CFG_BITS-1:0]);
      REG_MAX_WIDTH:     cfg_max = longint'(data[CFG_BITS-1:0]);
      REG_LINE_TOP:      cfg_top = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic set_layout(logic [31:0] adv, logic [31:0] maxw, logic [31:0] top);
    write_reg(REG_ADVANCE_WIDTH, adv);
    write_reg(REG_MAX_WIDTH, maxw);
    write_reg(REG_LINE_TOP, top);
    layouts++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (glyph_q.size() != 0 || glyph_bus.valid || union_box_q.size() != 0);
  endtask

  task automatic run_batch(int n);
    @(negedge clk);
    repeat (n) begin
      if (string_left == 0) begin
        string_left = $urandom_range(1, 12);
        glyph_q.push_back(random_glyph(1'b1));
      end else begin
        glyph_q.push_back(random_glyph(1'b0));
      end
      string_left--;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin : glyph_driver
    if (rst) begin
      glyph_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (glyph_bus.valid && glyph_bus.ready) begin
        union_box_q.push_back(place_glyph(glyph_bus.payload));
        glyphs_sent++;
      end
      if (!glyph_bus.valid || glyph_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          glyph_bus.valid <= 1'b0;
        end else if (glyph_q.size() != 0) begin
          glyph_bus.payload <= glyph_q.pop_front();
          glyph_bus.valid   <= 1'b1;
          send_gap = idle_span();
        end else begin
          glyph_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : box_monitor
    extent_t want;
    if (rst) begin
      box_bus.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (box_bus.valid && box_bus.ready) begin
        boxes_seen++;
        if (union_box_q.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("box beat %0d arrived with no glyph outstanding: %h", boxes_seen,
                     box_bus.payload);
        end else begin
          want = union_box_q.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (want[8*FIELD_BITS-1-FIELD_BITS*k -: FIELD_BITS] !==
                box_bus.payload[8*FIELD_BITS-1-FIELD_BITS*k -: FIELD_BITS]) begin
              faults++;
              if (faults <= 10)
                $display("box beat %0d %s: expected %0d, got %0d", boxes_seen, box_field[k],
                         $signed(want[8*FIELD_BITS-1-FIELD_BITS*k -: FIELD_BITS]),
                         $signed(box_bus.payload[8*FIELD_BITS-1-FIELD_BITS*k -: FIELD_BITS]));
            end
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_SPAN;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        box_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        box_bus.ready <= 1'b0;
      end else begin
        box_bus.ready <= 1'b1;
        stall_left = idle_span();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (glyph_bus.valid && glyph_bus.ready) || (box_bus.valid && box_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat for %0d cycles, %0d boxes outstanding", quiet_cycles,
               union_box_q.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    glyph_bus.valid   = 1'b0;
    glyph_bus.payload = '0;
    box_bus.ready     = 1'b0;
    cfg_adv           = 0;
    cfg_max           = 0;
    cfg_top           = 0;
    pen_pos           = 0;
    for (int k = 0; k < 8; k++) union_edge[k] = 0;
    faults            = 0;
    quiet_cycles      = 0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    string_left       = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset layout: no start flag first, squeeze to the floor factor, inverted box
    @(negedge clk);
    glyph_q.push_back(glyph_of(0, -100, 300, -90, 280, -50, 700, -40, 650));
    glyph_q.push_back(glyph_of(0, 50, -50, 40, -40, 10, 20, 10, 20));
    glyph_q.push_back(glyph_of(1, INT_MIN, INT_MAX, INT_MIN, INT_MAX,
                               INT_MIN, INT_MAX, INT_MIN, INT_MAX));
    glyph_q.push_back(glyph_of(0, INT_MAX, INT_MAX, INT_MAX, INT_MIN,
                               INT_MAX, INT_MIN, INT_MAX, INT_MIN));
    wait_drained();

    set_layout(32'd1000, 32'd600, 32'd800);
    @(negedge clk);
    glyph_q.push_back(glyph_of(1, 0, 600, 10, 590, -200, 900, -150, 850));
    glyph_q.push_back(glyph_of(0, 0, 601, 5, 600, -10, 100, 0, 90));
    glyph_q.push_back(glyph_of(0, -4800, 4800, -4700, 4700, -300, 500, -250, 450));
    glyph_q.push_back(glyph_of(0, 0, 9601, -20, 9700, 0, 10, 0, 10));
    glyph_q.push_back(glyph_of(0, -5000, -1000, -4999, -1001, -5, 5, -3, 3));
    glyph_q.push_back(glyph_of(0, 300, 100, 290, 110, 0, 0, 0, 0));
    glyph_q.push_back(glyph_of(1, -20, 40, -10, 30, -900, 100, -800, 90));
    wait_drained();

    // widest cells: pen and placed edges run into saturation
    set_layout(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    @(negedge clk);
    glyph_q.push_back(glyph_of(1, 0, 100, 2, 98, -10, 50, -5, 40));
    glyph_q.push_back(glyph_of(0, INT_MIN, INT_MAX, INT_MIN, INT_MAX, 0, 1, 0, 1));
    glyph_q.push_back(glyph_of(0, INT_MAX, INT_MIN, INT_MAX, INT_MIN, 0, 0, 0, 0));
    glyph_q.push_back(glyph_of(0, -1, 0, -1, 0, INT_MIN, INT_MIN, INT_MIN, INT_MIN));
    wait_drained();

    // narrow cells: negative odd offsets
    set_layout(32'd5, 32'd100, 32'd7);
    @(negedge clk);
    glyph_q.push_back(glyph_of(1, 0, 50, 1, 49, -3, 9, -2, 8));
    glyph_q.push_back(glyph_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    glyph_q.push_back(glyph_of(0, 0, 100, -7, 107, -1, 1, -1, 1));
    glyph_q.push_back(glyph_of(0, 0, 101, 3, 99, -2, 12, -2, 12));
    glyph_q.push_back(glyph_of(0, 0, 1700, -40, 1750, 0, 3, 0, 3));
    glyph_q.push_back(glyph_of(0, 10, -3, 9, -2, 4, 6, 4, 6));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1: set_layout({1'($urandom), 31'(rnd(0, 3000))}, 32'd0, 32'(rnd(-2000, 2000)));
        2: set_layout(32'h7FFF_FFFF, 32'(rnd(0, 2000)), 32'h8000_0000);
        3: set_layout($urandom, $urandom, $urandom);
        default: set_layout({1'($urandom), 31'(rnd(0, 3000))}, 32'(rnd(0, 2000)),
                            32'(rnd(-2000, 2000)));
      endcase
      @(negedge clk);
      quiet = (p % 3 == 1);
      if (p == 4) hold_req = 1'b1;
      if (p == 5) begin
        run_batch(BATCH / 2);
        wait_drained();
        run_batch(BATCH - BATCH / 2);
      end else begin
        run_batch(BATCH);
      end
      wait_drained();
    end

    repeat (40) @(negedge clk);
    faults += union_box_q.size();
    $display("%0d glyphs in %0d strings across %0d layouts, %0d boxes checked",
             glyphs_sent, strings_started, layouts, boxes_seen);
    $display("%0d long receiver hold(s), %0d field mismatches or stray beats",
             holds_done, faults);
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
